// ===== rtl/tlr_pkg.sv =====
// ============================================================================
// tlr_pkg: shared types and constants for the tile-map layer renderer
// Store sizes, command codes, register indexes and the words that pass
// between the address, fetch and output sections.
// ============================================================================
package tlr_pkg;

   localparam int MAP_ENTRIES   = 4096;
   localparam int TILE_COUNT    = 256;
   localparam int SCREEN_WIDTH  = 320;
   localparam int TEXEL_ENTRIES = TILE_COUNT * 64;

   localparam int MAP_AW = $clog2(MAP_ENTRIES);
   localparam int TILE_W = $clog2(TILE_COUNT);
   localparam int TEX_AW = $clog2(TEXEL_ENTRIES);

   // floor(2^32 / TILE_COUNT), for tile number reduction
   localparam logic [31:0] TILE_RECIP = 32'(64'h1_0000_0000 / TILE_COUNT);

   localparam int SUM_W       = 11;
   localparam int MIDX_W      = 15;
   localparam int WRAP_STEPS  = 8;
   localparam int ADDR_STAGES = WRAP_STEPS + 2;
   localparam int FETCH_STAGES = 4;
   localparam int CSR_AW      = 5;

   typedef enum logic [1:0] {
      CMD_MAP_LOAD   = 2'd0,
      CMD_TEXEL_LOAD = 2'd1,
      CMD_RENDER     = 2'd2
   } tlr_cmd_type;

   localparam logic [2:0] REG_LAYER_ENABLE      = 3'd0;
   localparam logic [2:0] REG_MAP_WIDTH_TILES   = 3'd1;
   localparam logic [2:0] REG_MAP_HEIGHT_TILES  = 3'd2;
   localparam logic [2:0] REG_SCROLL_X          = 3'd3;
   localparam logic [2:0] REG_SCROLL_Y          = 3'd4;
   localparam logic [2:0] REG_TRANSPARENT_COLOR = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] load_index;
      logic [15:0] load_value;
      logic [8:0]  screen_x;
      logic [7:0]  screen_y;
      logic [7:0]  under_color;
   } tlr_req_type;

   typedef struct packed {
      logic [7:0] pixel_color;
      logic       layer_drawn;
   } tlr_rsp_type;

   typedef struct packed {
      logic       layer_enable;
      logic [6:0] map_width_tiles;
      logic [6:0] map_height_tiles;
      logic [9:0] scroll_x;
      logic [9:0] scroll_y;
      logic [7:0] transparent_color;
   } tlr_cfg_type;

   typedef struct packed {
      tlr_cmd_type       cmd;
      logic              active;
      logic [13:0]       load_index;
      logic [15:0]       load_value;
      logic [7:0]        under;
      logic [SUM_W-1:0]  rx;
      logic [SUM_W-1:0]  ry;
      logic [MIDX_W-1:0] midx;
      logic              oob;
      logic [15:0]       raw;
      logic [15:0]       quo;
      logic [TEX_AW-1:0] taddr;
   } tlr_item_type;

endpackage

// ===== rtl/tlr_ram.sv =====
// ============================================================================
// tlr_ram: generic single-port synchronous RAM
// One access per cycle when enabled; read data registered, read-before-write.
// ============================================================================
module tlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tlr_addr.sv =====
// ============================================================================
// tlr_addr: scroll, wrap and map index pipeline
// Adds scroll, wraps both coordinates with an eight-step restoring modulo
// pipeline, then forms the tile map index. Loads ride along unchanged.
// ============================================================================
module tlr_addr (
   input  logic                 clock,
   input  logic                 reset,
   input  tlr_pkg::tlr_cfg_type cfg,
   input  logic                 in_valid,
   input  tlr_pkg::tlr_req_type in_word,
   output logic                 in_ready,
   output logic                 out_valid,
   output tlr_pkg::tlr_item_type out_item,
   input  logic                 out_ready
);

   localparam int N = tlr_pkg::ADDR_STAGES;

   tlr_pkg::tlr_item_type item_ff [N];
   tlr_pkg::tlr_item_type item_in [N];
   logic                  valid_ff [N];
   logic                  valid_in [N];
   logic                  stage_ready [N];
   logic [9:0]            pw;
   logic [9:0]            ph;

   function automatic logic [tlr_pkg::SUM_W-1:0] mod_step(
      input logic [tlr_pkg::SUM_W-1:0] v,
      input logic [9:0]                span,
      input int                        k
   );
      logic [17:0] d;
      d = 18'(span) << k;
      if (18'(v) >= d) begin
         return v - tlr_pkg::SUM_W'(d);
      end
      return v;
   endfunction

   assign pw = {cfg.map_width_tiles, 3'b000};
   assign ph = {cfg.map_height_tiles, 3'b000};

   always_comb begin
      item_in[0]            = '0;
      item_in[0].cmd        = tlr_pkg::tlr_cmd_type'(in_word.cmd);
      item_in[0].load_index = in_word.load_index;
      item_in[0].load_value = in_word.load_value;
      item_in[0].under      = in_word.under_color;
      item_in[0].active     = cfg.layer_enable && (cfg.map_width_tiles != 7'd0)
                              && (cfg.map_height_tiles != 7'd0)
                              && (12'(in_word.screen_x) < 12'(tlr_pkg::SCREEN_WIDTH));
      item_in[0].rx = tlr_pkg::SUM_W'(in_word.screen_x) + tlr_pkg::SUM_W'(cfg.scroll_x);
      item_in[0].ry = tlr_pkg::SUM_W'(in_word.screen_y) + tlr_pkg::SUM_W'(cfg.scroll_y);
      valid_in[0]   = in_valid && (in_word.cmd == tlr_pkg::CMD_MAP_LOAD
                                   || in_word.cmd == tlr_pkg::CMD_TEXEL_LOAD
                                   || in_word.cmd == tlr_pkg::CMD_RENDER);
      for (int i = 1; i <= tlr_pkg::WRAP_STEPS; i++) begin
         valid_in[i]   = valid_ff[i-1];
         item_in[i]    = item_ff[i-1];
         item_in[i].rx = mod_step(item_ff[i-1].rx, pw, tlr_pkg::WRAP_STEPS - i);
         item_in[i].ry = mod_step(item_ff[i-1].ry, ph, tlr_pkg::WRAP_STEPS - i);
      end
      valid_in[N-1]     = valid_ff[N-2];
      item_in[N-1]      = item_ff[N-2];
      item_in[N-1].midx = tlr_pkg::MIDX_W'(14'(item_ff[N-2].ry[9:3])
                                            * 14'(cfg.map_width_tiles))
                          + tlr_pkg::MIDX_W'(item_ff[N-2].rx[9:3]);
   end

   always_comb begin
      stage_ready[N-1] = !valid_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (stage_ready[i]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[N-1];
   assign out_item  = item_ff[N-1];

endmodule

// ===== rtl/tlr_fetch.sv =====
// ============================================================================
// tlr_fetch: tile map and texel store access
// Map read, tile number reduction in two steps, texel address, texel read.
// Loads write their store at the stage where renders read it, so order holds.
// ============================================================================
module tlr_fetch (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tlr_pkg::tlr_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output tlr_pkg::tlr_item_type out_item,
   output logic [7:0]            out_texel,
   input  logic                  out_ready
);

   localparam int N = tlr_pkg::FETCH_STAGES;

   tlr_pkg::tlr_item_type item_ff [N];
   tlr_pkg::tlr_item_type item_in [N];
   logic                  valid_ff [N];
   logic                  valid_in [N];
   logic                  stage_ready [N];

   logic                      map_we;
   logic [tlr_pkg::MAP_AW-1:0] map_ram_addr;
   logic [15:0]               map_rd;
   logic                      tex_we;
   logic [tlr_pkg::TEX_AW-1:0] tex_addr;
   logic [7:0]                tex_rd;
   logic [47:0]               recip_prod;
   logic [16:0]               quo_prod;
   logic [16:0]               rem;

   always_comb begin
      valid_in[0]     = in_valid;
      item_in[0]      = in_item;
      item_in[0].oob  = 32'(in_item.midx) >= 32'(tlr_pkg::MAP_ENTRIES);

      valid_in[1]     = valid_ff[0];
      item_in[1]      = item_ff[0];
      item_in[1].raw  = item_ff[0].oob ? 16'd0 : map_rd;
      recip_prod      = 48'(item_in[1].raw) * 48'(tlr_pkg::TILE_RECIP);
      item_in[1].quo  = recip_prod[47:32];

      valid_in[2]     = valid_ff[1];
      item_in[2]      = item_ff[1];
      quo_prod        = 17'(item_ff[1].quo) * 17'(tlr_pkg::TILE_COUNT);
      rem             = 17'(item_ff[1].raw) - quo_prod;
      if (rem >= 17'(tlr_pkg::TILE_COUNT)) begin
         rem = rem - 17'(tlr_pkg::TILE_COUNT);
      end
      item_in[2].taddr = {rem[tlr_pkg::TILE_W-1:0], item_ff[1].ry[2:0], item_ff[1].rx[2:0]};

      valid_in[3]     = valid_ff[2];
      item_in[3]      = item_ff[2];
   end

   always_comb begin
      stage_ready[N-1] = !valid_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign map_we   = stage_ready[0] && in_valid && (in_item.cmd == tlr_pkg::CMD_MAP_LOAD)
                     && (32'(in_item.load_index) < 32'(tlr_pkg::MAP_ENTRIES));
   assign map_ram_addr = map_we ? tlr_pkg::MAP_AW'(in_item.load_index)
                                : tlr_pkg::MAP_AW'(in_item.midx);

   assign tex_we   = stage_ready[3] && valid_ff[2]
                     && (item_ff[2].cmd == tlr_pkg::CMD_TEXEL_LOAD)
                     && (32'(item_ff[2].load_index) < 32'(tlr_pkg::TEXEL_ENTRIES));
   assign tex_addr = tex_we ? tlr_pkg::TEX_AW'(item_ff[2].load_index) : item_ff[2].taddr;

   tlr_ram #(
      .WIDTH (16),
      .DEPTH (tlr_pkg::MAP_ENTRIES)
   ) u_map_ram (
      .clock   (clock),
      .en      (stage_ready[0]),
      .we      (map_we),
      .addr    (map_ram_addr),
      .wr_data (in_item.load_value),
      .rd_data (map_rd)
   );

   tlr_ram #(
      .WIDTH (8),
      .DEPTH (tlr_pkg::TEXEL_ENTRIES)
   ) u_tex_ram (
      .clock   (clock),
      .en      (stage_ready[3]),
      .we      (tex_we),
      .addr    (tex_addr),
      .wr_data (item_ff[2].load_value[7:0]),
      .rd_data (tex_rd)
   );

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (stage_ready[i]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[N-1];
   assign out_item  = item_ff[N-1];
   assign out_texel = tex_rd;

endmodule

// ===== rtl/tilemap_layer_pixel_render.sv =====
// ============================================================================
// tilemap_layer_pixel_render: scrolling 8x8 tile-map background layer
// Pipelined renderer: one word accepted per cycle, loads and renders alike.
// ============================================================================
// A word is accepted every cycle while the pipeline has room; a render word
// gives its pixel after the scroll add, the eight-step wrap modulo pipeline
// and the map index stage, then map read, tile reduction by reciprocal
// multiply and remainder, texel read and output register. Stalls collapse
// bubbles stage by stage, so up to 15 words sit in flight. Map and texel
// loads write their store in acceptance order relative to renders and give
// no response. Neither store is cleared after reset; a store entry must be
// loaded before it is used.
// Registers sit at byte addresses 0, 4, ... 20 and read back their value.
module tilemap_layer_pixel_render (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tlr_pkg::tlr_req_type         req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tlr_pkg::tlr_rsp_type         rsp_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tlr_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   tlr_pkg::tlr_cfg_type  cfg_ff;
   logic                  addr_ready;
   logic                  addr_valid;
   tlr_pkg::tlr_item_type addr_item;
   logic                  fetch_ready;
   logic                  fetch_valid;
   tlr_pkg::tlr_item_type fetch_item;
   logic [7:0]            fetch_texel;
   logic                  out_ready;
   logic                  rsp_valid_ff;
   tlr_pkg::tlr_rsp_type  rsp_word_ff;
   tlr_pkg::tlr_rsp_type  rsp_word_in;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            tlr_pkg::REG_LAYER_ENABLE:      cfg_ff.layer_enable      <= pwdata[0];
            tlr_pkg::REG_MAP_WIDTH_TILES:   cfg_ff.map_width_tiles   <= pwdata[6:0];
            tlr_pkg::REG_MAP_HEIGHT_TILES:  cfg_ff.map_height_tiles  <= pwdata[6:0];
            tlr_pkg::REG_SCROLL_X:          cfg_ff.scroll_x          <= pwdata[9:0];
            tlr_pkg::REG_SCROLL_Y:          cfg_ff.scroll_y          <= pwdata[9:0];
            tlr_pkg::REG_TRANSPARENT_COLOR: cfg_ff.transparent_color <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         tlr_pkg::REG_LAYER_ENABLE:      prdata = 32'(cfg_ff.layer_enable);
         tlr_pkg::REG_MAP_WIDTH_TILES:   prdata = 32'(cfg_ff.map_width_tiles);
         tlr_pkg::REG_MAP_HEIGHT_TILES:  prdata = 32'(cfg_ff.map_height_tiles);
         tlr_pkg::REG_SCROLL_X:          prdata = 32'(cfg_ff.scroll_x);
         tlr_pkg::REG_SCROLL_Y:          prdata = 32'(cfg_ff.scroll_y);
         tlr_pkg::REG_TRANSPARENT_COLOR: prdata = 32'(cfg_ff.transparent_color);
         default:                        prdata = 32'd0;
      endcase
   end

   tlr_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .in_ready  (addr_ready),
      .out_valid (addr_valid),
      .out_item  (addr_item),
      .out_ready (fetch_ready)
   );

   tlr_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (addr_valid),
      .in_item   (addr_item),
      .in_ready  (fetch_ready),
      .out_valid (fetch_valid),
      .out_item  (fetch_item),
      .out_texel (fetch_texel),
      .out_ready (out_ready)
   );

   assign req_stall = !addr_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (fetch_item.active && (fetch_texel != cfg_ff.transparent_color)) begin
         rsp_word_in.pixel_color = fetch_texel;
         rsp_word_in.layer_drawn = 1'b1;
      end else begin
         rsp_word_in.pixel_color = fetch_item.under;
         rsp_word_in.layer_drawn = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= fetch_valid && (fetch_item.cmd == tlr_pkg::CMD_RENDER);
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/tlr_port_chk.sv =====
// ============================================================================
// tlr_port_chk: port-level checks for the tile-map layer renderer
// Watches the top level's ports only; attached by the bind below.
// ============================================================================
module tlr_port_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input tlr_pkg::tlr_req_type       req_word,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input tlr_pkg::tlr_rsp_type       rsp_word,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [tlr_pkg::CSR_AW-1:0] paddr,
   input logic [31:0]                pwdata,
   input logic [31:0]                prdata,
   input logic                       pready
);

   // no response word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input backs up only when every stage and the output are full and stalled
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // held request word
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_word)))
      else $error("stalled request changed");

   // held response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response changed");

   // scroll_x read right after a write returns the written bits
   a_scroll_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[4:2] == tlr_pkg::REG_SCROLL_X)
      ##1 (psel && !pwrite && paddr[4:2] == tlr_pkg::REG_SCROLL_X)
      |-> (prdata[9:0] == $past(pwdata[9:0]) && prdata[31:10] == 22'd0))
      else $error("scroll_x readback mismatch");

endmodule

bind tilemap_layer_pixel_render tlr_port_chk u_port_chk (.*);

// ===== sim/tlr_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// tlr_pixel_checker: result predictor and scoreboard for the tile-map layer
// Watches the request, result and register ports. Keeps its own copy of the
// tile map, the tile colors and the layer registers, predicts the pixel for
// every accepted render word and compares each result word in order.
// ----------------------------------------------------------------------------
module tlr_pixel_checker
   import tlr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  tlr_req_type         req_word,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  tlr_rsp_type         rsp_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output int                  mismatches,
   output int                  pixels_pending,
   output int                  pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TILE_DIM    = 8;
   localparam int TILE_TEXELS = 64;

   tlr_cfg_type layer_cfg;
   logic [15:0] tile_numbers [MAP_ENTRIES];
   logic [7:0]  tile_colors [TEXEL_ENTRIES];
   tlr_rsp_type expected_pixels [$];

   function automatic tlr_rsp_type predict_pixel(tlr_req_type w);
      tlr_rsp_type p;
      int          width, height, px, py, midx, tile, tidx;
      p.pixel_color = w.under_color;
      p.layer_drawn = 1'b0;
      width  = int'(layer_cfg.map_width_tiles);
      height = int'(layer_cfg.map_height_tiles);
      if (layer_cfg.layer_enable && width != 0 && height != 0
          && int'(w.screen_x) < SCREEN_WIDTH) begin
         px   = (int'(w.screen_x) + int'(layer_cfg.scroll_x)) % (width * TILE_DIM);
         py   = (int'(w.screen_y) + int'(layer_cfg.scroll_y)) % (height * TILE_DIM);
         midx = (py / TILE_DIM) * width + px / TILE_DIM;
         // map reads past the store give tile 0
         tile = (midx < MAP_ENTRIES) ? int'(tile_numbers[midx]) % TILE_COUNT : 0;
         tidx = tile * TILE_TEXELS + (py % TILE_DIM) * TILE_DIM + px % TILE_DIM;
         if (tile_colors[tidx] != layer_cfg.transparent_color) begin
            p.pixel_color = tile_colors[tidx];
            p.layer_drawn = 1'b1;
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      tlr_rsp_type want;
      if (reset) begin
         layer_cfg = '0;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_AW-1:2])
               REG_LAYER_ENABLE:      layer_cfg.layer_enable      = pwdata[0];
               REG_MAP_WIDTH_TILES:   layer_cfg.map_width_tiles   = pwdata[6:0];
               REG_MAP_HEIGHT_TILES:  layer_cfg.map_height_tiles  = pwdata[6:0];
               REG_SCROLL_X:          layer_cfg.scroll_x          = pwdata[9:0];
               REG_SCROLL_Y:          layer_cfg.scroll_y          = pwdata[9:0];
               REG_TRANSPARENT_COLOR: layer_cfg.transparent_color = pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_word.cmd)
               CMD_MAP_LOAD: begin
                  if (int'(req_word.load_index) < MAP_ENTRIES)
                     tile_numbers[req_word.load_index] = req_word.load_value;
               end
               CMD_TEXEL_LOAD: begin
                  if (int'(req_word.load_index) < TEXEL_ENTRIES)
                     tile_colors[req_word.load_index] = req_word.load_value[7:0];
               end
               CMD_RENDER: expected_pixels.push_back(predict_pixel(req_word));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result word: pixel_color %0d, layer_drawn %0d",
                      rsp_word.pixel_color, rsp_word.layer_drawn);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_word.pixel_color !== want.pixel_color) begin
                  $error("pixel_color: expected %0d, actual %0d",
                         want.pixel_color, rsp_word.pixel_color);
                  mismatches++;
               end
               if (rsp_word.layer_drawn !== want.layer_drawn) begin
                  $error("layer_drawn: expected %0d, actual %0d",
                         want.layer_drawn, rsp_word.layer_drawn);
                  mismatches++;
               end
            end
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

// ===== sim/tb_tilemap_layer_pixel_render.sv =====
// ----------------------------------------------------------------------------
// tb_tilemap_layer_pixel_render: stimulus and verdict for the tile-map layer
// Loads tiles and map entries on demand so renders only read loaded entries,
// sweeps the layer registers through disabled, minimum, maximum and oversized
// maps, and runs bursty requests against a result stall pattern.
// ----------------------------------------------------------------------------
module tb_tilemap_layer_pixel_render;
   timeunit 1ns;
   timeprecision 1ps;
   import tlr_pkg::*;

   localparam int         TILE_DIM        = 8;
   localparam int         TILE_TEXELS     = 64;
   localparam int         FLUSH_CYCLES    = 20;
   localparam int         WATCHDOG_CYCLES = 2000;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;

   typedef enum int {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_BURSTY
   } stall_mode_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   tlr_req_type         req_word    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   tlr_rsp_type         rsp_word;
   logic                psel        = 1'b0;
   logic                penable     = 1'b0;
   logic                pwrite      = 1'b0;
   logic [CSR_AW-1:0]   paddr       = '0;
   logic [31:0]         pwdata      = '0;
   logic [31:0]         prdata;
   logic                pready;

   int mismatches, pixels_pending, pixels_checked;

   tilemap_layer_pixel_render u_top (.*);
   tlr_pixel_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_cycles = 0;
   int             stall_run = 0;

   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  = stall_mode_type'($urandom_range(0, 4));
         mode_cycles = $urandom_range(30, 150);
      end
      mode_cycles--;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 7) == 0);
         STALL_HEAVY:    rsp_stall <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_stall <= (mode_cycles % 4 != 0);
         default: begin
            if (stall_run == 0 && $urandom_range(0, 5) == 0)
               stall_run = $urandom_range(5, 25);
            rsp_stall <= (stall_run != 0);
            if (stall_run != 0)
               stall_run--;
         end
      endcase
   end

   // watchdog on words moving through either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus state
   tlr_cfg_type layer_now = '0;
   bit          steady = 1'b0;
   int          burst_left = 0;
   int          render_words = 0, load_words = 0, other_words = 0, settings = 0;
   bit          map_loaded [MAP_ENTRIES];
   logic [15:0] map_shadow [MAP_ENTRIES];
   bit          texel_loaded [TEXEL_ENTRIES];

   function automatic tlr_req_type random_word(logic [1:0] cmd);
      tlr_req_type w;
      w.cmd         = cmd;
      w.load_index  = 14'($urandom);
      w.load_value  = 16'($urandom);
      w.screen_x    = 9'($urandom);
      w.screen_y    = 8'($urandom);
      w.under_color = 8'($urandom);
      return w;
   endfunction

   function automatic logic [15:0] texel_value();
      if ($urandom_range(0, 3) == 0)
         return {8'($urandom), layer_now.transparent_color};
      return 16'($urandom);
   endfunction

   function automatic tlr_cfg_type layer_setting(int en, int w, int h, int sx, int sy, int tc);
      tlr_cfg_type c;
      c.layer_enable      = 1'(en);
      c.map_width_tiles   = 7'(w);
      c.map_height_tiles  = 7'(h);
      c.scroll_x          = 10'(sx);
      c.scroll_y          = 10'(sy);
      c.transparent_color = 8'(tc);
      return c;
   endfunction

   task automatic send_word(tlr_req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (steady)
            gap = 0;
         else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(10, 40);
         else
            gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      case (w.cmd)
         CMD_RENDER:                   render_words++;
         CMD_MAP_LOAD, CMD_TEXEL_LOAD: load_words++;
         default:                      other_words++;
      endcase
   endtask

   task automatic load_map(int index, logic [15:0] value);
      tlr_req_type w;
      w = random_word(CMD_MAP_LOAD);
      w.load_index = 14'(index);
      w.load_value = value;
      if (index < MAP_ENTRIES) begin
         map_loaded[index] = 1'b1;
         map_shadow[index] = value;
      end
      send_word(w);
   endtask

   task automatic load_texel(int index, logic [15:0] value);
      tlr_req_type w;
      w = random_word(CMD_TEXEL_LOAD);
      w.load_index = 14'(index);
      w.load_value = value;
      texel_loaded[index] = 1'b1;
      send_word(w);
   endtask

   // loads any map entry and texel the pixel reads that is not loaded yet, then renders it
   task automatic render_pixel(int sx, int sy, logic [7:0] under);
      tlr_req_type w;
      int          width, height, px, py, midx, tile, tidx;
      width  = int'(layer_now.map_width_tiles);
      height = int'(layer_now.map_height_tiles);
      if (layer_now.layer_enable && width != 0 && height != 0 && sx < SCREEN_WIDTH) begin
         px   = (sx + int'(layer_now.scroll_x)) % (width * TILE_DIM);
         py   = (sy + int'(layer_now.scroll_y)) % (height * TILE_DIM);
         midx = (py / TILE_DIM) * width + px / TILE_DIM;
         if (midx < MAP_ENTRIES && !map_loaded[midx])
            load_map(midx, 16'($urandom));
         tile = (midx < MAP_ENTRIES) ? int'(map_shadow[midx]) % TILE_COUNT : 0;
         tidx = tile * TILE_TEXELS + (py % TILE_DIM) * TILE_DIM + px % TILE_DIM;
         if (!texel_loaded[tidx])
            load_texel(tidx, texel_value());
      end
      w = random_word(CMD_RENDER);
      w.screen_x    = 9'(sx);
      w.screen_y    = 8'(sy);
      w.under_color = under;
      send_word(w);
   endtask

   task automatic csr_write(logic [2:0] reg_index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // registers change only with the pipeline empty
   task automatic set_layer(tlr_cfg_type c);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (FLUSH_CYCLES) @(negedge clock);
      csr_write(REG_LAYER_ENABLE,      32'(c.layer_enable));
      csr_write(REG_MAP_WIDTH_TILES,   32'(c.map_width_tiles));
      csr_write(REG_MAP_HEIGHT_TILES,  32'(c.map_height_tiles));
      csr_write(REG_SCROLL_X,          32'(c.scroll_x));
      csr_write(REG_SCROLL_Y,          32'(c.scroll_y));
      csr_write(REG_TRANSPARENT_COLOR, 32'(c.transparent_color));
      layer_now = c;
      steady    = ($urandom_range(0, 2) == 0);
      settings++;
   endtask

   task automatic random_ops(int count);
      int pick, sx;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         sx   = ($urandom_range(0, 9) == 0) ? $urandom_range(SCREEN_WIDTH, 511)
                                            : $urandom_range(0, SCREEN_WIDTH - 1);
         if (pick < 70)
            render_pixel(sx, $urandom_range(0, 255), 8'($urandom));
         else if (pick < 80)
            load_texel($urandom_range(0, TEXEL_ENTRIES - 1), texel_value());
         else if (pick < 88)
            load_map($urandom_range(0, MAP_ENTRIES - 1), 16'($urandom));
         else if (pick < 94)
            load_map($urandom_range(MAP_ENTRIES, 16383), 16'($urandom));
         else
            send_word(random_word(CMD_UNUSED));
      end
   endtask

   initial begin
      int rand_w, rand_h;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // layer off after reset, ignored loads, unused command
      render_pixel(0, 0, 8'h00);
      render_pixel(511, 255, 8'hFF);
      send_word('1);
      load_map(16383, 16'hFFFF);
      load_map(MAP_ENTRIES, 16'h8001);
      load_texel(TEXEL_ENTRIES - 1, 16'hFF5A);

      // single tile map, tile number masked to the tile count
      set_layer(layer_setting(1, 1, 1, 0, 0, 0));
      load_map(0, 16'hFFFF);
      load_texel((TILE_COUNT - 1) * TILE_TEXELS, 16'hFF00);
      load_texel(TEXEL_ENTRIES - 1, 16'h00AB);
      render_pixel(0, 0, 8'h77);
      render_pixel(319, 239, 8'h55);
      render_pixel(320, 0, 8'h33);
      render_pixel(511, 255, 8'h99);
      render_pixel(7, 0, 8'hFF);
      random_ops(15);

      set_layer(layer_setting(1, 64, 64, 1023, 1023, 255));
      render_pixel(0, 0, 8'h01);
      render_pixel(319, 239, 8'hFE);
      random_ops(25);

      // oversized map, reads of its bottom rows fall past the store
      set_layer(layer_setting(1, 127, 127, 1000, 1000, 0));
      render_pixel(0, 0, 8'h3C);
      random_ops(25);

      set_layer(layer_setting(1, 1, 64, 0, 512, $urandom_range(0, 255)));
      random_ops(25);
      set_layer(layer_setting(0, 8, 8, 5, 5, 0));
      random_ops(15);
      set_layer(layer_setting(1, 0, 8, 0, 0, 0));
      random_ops(12);
      set_layer(layer_setting(1, 8, 0, 0, 0, 0));
      random_ops(12);

      repeat (5) begin
         rand_w = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
         rand_h = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
         set_layer(layer_setting(1, rand_w, rand_h, $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 255)));
         random_ops(28);
      end

      req_valid <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (FLUSH_CYCLES) @(negedge clock);

      $display("Sent %0d words (%0d renders, %0d loads, %0d unused) over %0d layer settings.",
               render_words + load_words + other_words, render_words, load_words,
               other_words, settings);
      $display("Checked %0d pixels, %0d mismatches.", pixels_checked, mismatches);
      if (mismatches == 0 && pixels_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
